// ----- rtl/u2d_pkg.sv -----
`timescale 1ns / 1ps

package u2d_pkg;

  // One input item: a raw byte and the end-of-buffer mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  // One result item.
  typedef struct packed {
    logic        emitted;
    logic [15:0] code_point;
    logic        end_of_text;
  } out_t;

  localparam int unsigned PendW   = 2;
  localparam int unsigned PartW   = 15;
  localparam int unsigned FullW   = PartW + 6;

  localparam logic [15:0] CpQuestion = 16'h003F;
  localparam logic [15:0] CpReplace  = 16'hFFFD;

  // Lead byte prefixes, compared against the top bits of the byte.
  localparam logic [2:0] Lead2Pfx = 3'b110;
  localparam logic [3:0] Lead3Pfx = 4'b1110;
  localparam logic [4:0] Lead4Pfx = 5'b11110;

  // Continuation bytes still expected after each lead kind.
  localparam logic [PendW-1:0] PendNone = 2'd0;
  localparam logic [PendW-1:0] PendOne  = 2'd1;
  localparam logic [PendW-1:0] PendTwo  = 2'd2;
  localparam logic [PendW-1:0] PendThr  = 2'd3;

endpackage

// ----- rtl/u2d_in_if.sv -----
`timescale 1ns / 1ps

interface u2d_in_if;
  logic         valid;
  logic         ready;
  u2d_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/u2d_out_if.sv -----
`timescale 1ns / 1ps

interface u2d_out_if;
  logic          valid;
  logic          ready;
  u2d_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/utf8_to_ucs2_decoder.sv -----
`timescale 1ns / 1ps

// UTF-8 to UCS-2 stream decoder. Each accepted byte on in_i gives exactly one
// result on out_o, in order: emitted is set when the byte completes a
// character (ASCII, the last byte of a multi-byte sequence, or a bad lead
// that maps to '?'), and code_point is zero whenever emitted is clear.
// Bytes after a lead are taken as continuations without checking their top
// bits; overlong forms decode as they are, and a four-byte value above
// 0xFFFF comes out as 0xFFFD. end_of_text echoes end_of_buffer, and a
// sequence still open after that byte is dropped. Throughput is one byte per
// clock while out_o is ready: the decode is a single shallow stage between
// the sequence state and one result register, so a valid result appears in
// the cycle after the input transfer, and a new byte is taken in the same
// cycle the held result is transferred out.
module utf8_to_ucs2_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  u2d_in_if.sink        in_i,
  u2d_out_if.source     out_o
);

  // Sequence state: continuation bytes still expected and bits so far.
  logic [u2d_pkg::PendW-1:0] bytes_pending_q, bytes_pending_d;
  logic [u2d_pkg::PartW-1:0] partial_value_q, partial_value_d;

  // Result register.
  logic          out_valid_q, out_valid_d;
  u2d_pkg::out_t out_data_q, out_data_d;

  logic                      in_xfer;
  logic [7:0]                byte_w;
  logic [u2d_pkg::FullW-1:0] full_w;
  logic [u2d_pkg::PendW-1:0] pend_dec;

  // Take a new byte whenever the result register is empty or drains now.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  assign byte_w   = in_i.data.data_byte;
  assign full_w   = {partial_value_q, byte_w[5:0]};
  assign pend_dec = bytes_pending_q - u2d_pkg::PendOne;

  always_comb begin
    bytes_pending_d         = bytes_pending_q;
    partial_value_d         = partial_value_q;
    out_data_d              = out_data_q;
    out_valid_d             = out_valid_q && !out_o.ready;

    if (in_xfer) begin
      out_valid_d             = 1'b1;
      out_data_d.emitted      = 1'b0;
      out_data_d.code_point   = '0;
      out_data_d.end_of_text  = in_i.data.end_of_buffer;

      if (bytes_pending_q != u2d_pkg::PendNone) begin
        // Continuation: shift six payload bits in, no check on the prefix.
        bytes_pending_d = pend_dec;
        if (pend_dec == u2d_pkg::PendNone) begin
          out_data_d.emitted = 1'b1;
          // Anything past 16 bits is outside UCS-2: substitute.
          if (full_w[u2d_pkg::FullW-1:16] != '0) begin
            out_data_d.code_point = u2d_pkg::CpReplace;
          end else begin
            out_data_d.code_point = full_w[15:0];
          end
          partial_value_d = '0;
        end else begin
          partial_value_d = full_w[u2d_pkg::PartW-1:0];
        end
      end else if (!byte_w[7]) begin
        // ASCII passes straight through.
        out_data_d.emitted    = 1'b1;
        out_data_d.code_point = {8'h00, byte_w};
      end else if (byte_w[7:5] == u2d_pkg::Lead2Pfx) begin
        bytes_pending_d = u2d_pkg::PendOne;
        partial_value_d = {{(u2d_pkg::PartW-5){1'b0}}, byte_w[4:0]};
      end else if (byte_w[7:4] == u2d_pkg::Lead3Pfx) begin
        bytes_pending_d = u2d_pkg::PendTwo;
        partial_value_d = {{(u2d_pkg::PartW-4){1'b0}}, byte_w[3:0]};
      end else if (byte_w[7:3] == u2d_pkg::Lead4Pfx) begin
        bytes_pending_d = u2d_pkg::PendThr;
        partial_value_d = {{(u2d_pkg::PartW-3){1'b0}}, byte_w[2:0]};
      end else begin
        // Stray continuation or impossible lead.
        out_data_d.emitted    = 1'b1;
        out_data_d.code_point = u2d_pkg::CpQuestion;
      end

      // End of buffer: drop whatever sequence is still open.
      if (in_i.data.end_of_buffer) begin
        bytes_pending_d = u2d_pkg::PendNone;
        partial_value_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_pending_q <= u2d_pkg::PendNone;
      partial_value_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      bytes_pending_q <= bytes_pending_d;
      partial_value_q <= partial_value_d;
      out_valid_q     <= out_valid_d;
    end
  end

  // Payload holds without reset.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ----- tb/sv/ucs2_stream_checker.sv -----
`timescale 1ns / 1ps

module ucs2_stream_checker (
  input  logic clk_i,
  input  logic rst_ni,
  u2d_in_if    bytes_i,
  u2d_out_if   chars_i,
  output int   fail_count_o,
  output int   open_count_o
);

  u2d_pkg::out_t             chars_due_q[$];
  logic [u2d_pkg::PendW-1:0] cont_left;
  logic [u2d_pkg::PartW-1:0] acc_bits;
  int                        mismatches;

  always @(posedge clk_i or negedge rst_ni) begin : watch
    u2d_pkg::out_t             want;
    u2d_pkg::out_t             next;
    logic [7:0]                b;
    logic [u2d_pkg::FullW-1:0] full;
    if (!rst_ni) begin
      chars_due_q.delete();
      cont_left  = u2d_pkg::PendNone;
      acc_bits   = '0;
      mismatches = 0;
    end else begin
      // Compare first: a result never belongs to a byte taken at the same edge.
      if (chars_i.valid && chars_i.ready) begin
        if (chars_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: emitted=%0b code_point=%h end_of_text=%0b",
                     chars_i.data.emitted, chars_i.data.code_point,
                     chars_i.data.end_of_text);
          end
        end else begin
          want = chars_due_q.pop_front();
          if (chars_i.data.emitted !== want.emitted ||
              chars_i.data.code_point !== want.code_point ||
              chars_i.data.end_of_text !== want.end_of_text) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"mismatch: expected emitted=%0b code_point=%h end_of_text=%0b,",
                        " got emitted=%0b code_point=%h end_of_text=%0b"},
                       want.emitted, want.code_point, want.end_of_text,
                       chars_i.data.emitted, chars_i.data.code_point,
                       chars_i.data.end_of_text);
            end
          end
        end
      end

      if (bytes_i.valid && bytes_i.ready) begin
        b                = bytes_i.data.data_byte;
        next             = '0;
        next.end_of_text = bytes_i.data.end_of_buffer;
        if (cont_left != u2d_pkg::PendNone) begin
          // Any byte counts as a continuation; keep its low six bits.
          full      = {acc_bits, b[5:0]};
          cont_left = cont_left - u2d_pkg::PendOne;
          if (cont_left == u2d_pkg::PendNone) begin
            next.emitted    = 1'b1;
            next.code_point = (full[u2d_pkg::FullW-1:16] != '0) ?
                              u2d_pkg::CpReplace : full[15:0];
            acc_bits        = '0;
          end else begin
            acc_bits = full[u2d_pkg::PartW-1:0];
          end
        end else if (b[7] == 1'b0) begin
          next.emitted    = 1'b1;
          next.code_point = {8'h00, b};
        end else if (b[7:5] == u2d_pkg::Lead2Pfx) begin
          cont_left = u2d_pkg::PendOne;
          acc_bits  = u2d_pkg::PartW'(b[4:0]);
        end else if (b[7:4] == u2d_pkg::Lead3Pfx) begin
          cont_left = u2d_pkg::PendTwo;
          acc_bits  = u2d_pkg::PartW'(b[3:0]);
        end else if (b[7:3] == u2d_pkg::Lead4Pfx) begin
          cont_left = u2d_pkg::PendThr;
          acc_bits  = u2d_pkg::PartW'(b[2:0]);
        end else begin
          next.emitted    = 1'b1;
          next.code_point = u2d_pkg::CpQuestion;
        end
        if (bytes_i.data.end_of_buffer) begin
          cont_left = u2d_pkg::PendNone;
          acc_bits  = '0;
        end
        chars_due_q = {chars_due_q, next};
      end
    end
    fail_count_o <= mismatches;
    open_count_o <= chars_due_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RandomItems = 450;
  // Watchdog limit, set far above what the slowest run needs.
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned QuietTail   = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          fail_count;
  int          open_count;
  int          sent;
  bit          gaps_on;
  int unsigned cycles = 0;

  u2d_in_if  byte_ch ();
  u2d_out_if char_ch ();

  utf8_to_ucs2_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (char_ch)
  );

  // Passive checker: predicts each result from the byte stream and compares.
  ucs2_stream_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bytes_i      (byte_ch),
    .chars_i      (char_ch),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: alternate random stall bursts with stretches of ready.
  // Stalls stop once the quiet tail of the run begins.
  initial begin : sink_side
    int span;
    char_ch.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        char_ch.ready <= 1'b0;
        span = $urandom_range(1, 18);
      end else begin
        char_ch.ready <= 1'b1;
        span = $urandom_range(1, 24);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  // Present one byte and hold it until the decoder takes it. An idle burst
  // may come first; valid drops only in a step where it is not raised again.
  task automatic send_byte(input logic [7:0] b, input logic eob);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data  <= {b, eob};
    do @(posedge clk_i); while (!byte_ch.ready);
    sent++;
  endtask

  // One character as a well-formed UTF-8 sequence with random content, or a
  // lone noise byte. Some continuations are replaced by arbitrary bytes and
  // an end-of-buffer mark can land on any byte, cutting the sequence short.
  task automatic send_char();
    logic [20:0] cp;
    logic [7:0]  unit [4];
    int          len;
    int          pick;
    cp   = 21'($urandom);
    pick = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) begin
      unit[k] = 8'($urandom);
    end
    if (pick <= 2) begin
      len     = 1;
      unit[0] = {1'b0, cp[6:0]};
    end else if (pick <= 4) begin
      len     = 2;
      unit[0] = {u2d_pkg::Lead2Pfx, cp[10:6]};
    end else if (pick <= 6) begin
      len     = 3;
      unit[0] = {u2d_pkg::Lead3Pfx, cp[15:12]};
    end else if (pick <= 8) begin
      len = 4;
      // Keep some four-byte values inside 16 bits.
      if ($urandom_range(0, 3) == 0) begin
        cp[20:16] = '0;
      end
      unit[0] = {u2d_pkg::Lead4Pfx, cp[20:18]};
    end else begin
      len = 1;
    end
    // Fill continuations from the low end of the code point.
    for (int k = 1; k < len; k++) begin
      if ($urandom_range(0, 9) != 0) begin
        unit[k] = {2'b10, cp[6 * (len - 1 - k) +: 6]};
      end
    end
    for (int k = 0; k < len; k++) begin
      send_byte(unit[k], $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin : stimulus
    int stop_at;
    rst_ni        = 1'b0;
    gaps_on       = 1'b1;
    sent          = 0;
    byte_ch.valid = 1'b0;
    byte_ch.data  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ASCII extremes, stray continuation, invalid lead.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Two-byte character, then an overlong two-byte zero.
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    // Largest three-byte value.
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // Four-byte value just beyond 16 bits: replacement character.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // Overlong four-byte zero decodes as is.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // Continuation taken without checking its top bits.
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    // Sequence cut by end of buffer, on a continuation and on a lead.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hF0, 1'b1);
    send_byte(8'h41, 1'b1);

    // Random: mostly well-formed characters, some noise and cut sequences.
    stop_at = sent + RandomItems;
    while (sent < stop_at) begin
      if (sent + QuietTail >= stop_at) begin
        gaps_on = 1'b0;
      end
      send_char();
    end
    byte_ch.valid <= 1'b0;

    // Drain, then let the registered outputs settle.
    while (open_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (fail_count == 0 && open_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- utf8_to_ucs2_decoder.f -----
rtl/u2d_pkg.sv
rtl/u2d_in_if.sv
rtl/u2d_out_if.sv
rtl/utf8_to_ucs2_decoder.sv
tb/sv/ucs2_stream_checker.sv
tb/sv/testbench.sv
